/* src/cbr_pkg.sv */
`default_nettype none

package cbr_pkg;

   localparam int SAMPLE_BITS        = 24;
   localparam int LINE_DEPTH_DEFAULT = 4096;
   localparam int LINE_BITS          = 32;
   localparam int NUM_COMBS          = 3;
   localparam int DELAY_BITS         = 12;
   localparam int GAIN_BITS          = 16;
   localparam int WET_BITS           = 17;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int CSR_DATA_BITS      = 17;

   localparam logic [DELAY_BITS-1:0] DELAY_FIRST_RESET  = 12'd1488;
   localparam logic [DELAY_BITS-1:0] DELAY_SECOND_RESET = 12'd2064;
   localparam logic [DELAY_BITS-1:0] DELAY_THIRD_RESET  = 12'd2736;
   localparam logic [GAIN_BITS-1:0]  DECAY_RESET        = 16'd32768;
   localparam logic [GAIN_BITS-1:0]  DECAY_MIN          = 16'd3277;
   localparam logic [GAIN_BITS-1:0]  DECAY_MAX          = 16'd64225;
   localparam logic [WET_BITS-1:0]   WET_RESET          = 17'd0;
   localparam logic [WET_BITS-1:0]   WET_FULL           = 17'd65536;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DELAY_FIRST  = 3'd0,
      CSR_DELAY_SECOND = 3'd1,
      CSR_DELAY_THIRD  = 3'd2,
      CSR_DECAY_GAIN   = 3'd3,
      CSR_WET_LEVEL    = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_FB_MUL,
      ST_FB_ADD,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_MIX_DRY,
      ST_MIX_WET,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] audio_sample;
      logic                          tail_step;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] mixed_sample;
      logic                          clipped;
   } rsp_word_type;

endpackage

`default_nettype wire

/* src/comb_bank_reverb_unit.sv */
// The single shared 33x18 multiplier (three feedback products plus two mix products)
// and a 9-step radix-16 divide-by-three set the pace; a new req word is taken
// only after the previous result has been loaded into the rsp register.
// Reset (synchronous): config registers return to defaults, then a sweep over
// every line address zeroes the three delay lines with req_ready low; csr writes
// are taken throughout the sweep.
`default_nettype none

module comb_bank_reverb_unit #(
   parameter int LINE_DEPTH = cbr_pkg::LINE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cbr_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cbr_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cbr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cbr_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import cbr_pkg::*;

   // address widths; CW holds position + depth for the wrap sum
   localparam int AW = $clog2(LINE_DEPTH);
   localparam int CW = (AW >= DELAY_BITS) ? AW + 1 : DELAY_BITS + 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(LINE_DEPTH - 1);

   // shared multiplier: signed 33 x signed 18
   localparam int MA_BITS   = LINE_BITS + 1;
   localparam int MB_BITS   = WET_BITS + 1;
   localparam int PROD_BITS = MA_BITS + MB_BITS;
   localparam int RND_SHIFT = GAIN_BITS;
   localparam int RES_BITS  = PROD_BITS - RND_SHIFT;
   localparam int LS_BITS   = RES_BITS + 1;
   localparam int SUM_BITS  = LINE_BITS + 2;
   localparam logic signed [PROD_BITS-1:0] HALF_LSB = PROD_BITS'(64'sd1 <<< (RND_SHIFT - 1));

   localparam logic signed [LS_BITS-1:0] LINE_HI =
      LS_BITS'((64'sd1 <<< (LINE_BITS - 1)) - 64'sd1);
   localparam logic signed [LS_BITS-1:0] LINE_LO = -LINE_HI - LS_BITS'(1);
   localparam logic signed [RES_BITS-1:0] OUT_HI =
      RES_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [RES_BITS-1:0] OUT_LO = -OUT_HI - RES_BITS'(1);

   // divide by three, one hex digit per cycle; floor(t*43/128) == floor(t/3) for t < 128
   localparam int DIV_DIGITS = 9;
   localparam int DIV_BITS   = 4 * DIV_DIGITS;
   localparam int DCNT_BITS  = $clog2(DIV_DIGITS);
   localparam logic [5:0] DIV3_RECIP = 6'd43;
   localparam int DIV3_SHIFT = 7;

   // ---------------------------------------------------------------- state
   state_type                      state_ff, state_in;
   logic [AW-1:0]                  wp_ff;
   logic [1:0]                     comb_ff;
   logic [AW-1:0]                  raddr_ff [NUM_COMBS];
   logic signed [LINE_BITS-1:0]    rdata_ff [NUM_COMBS];
   logic signed [SAMPLE_BITS-1:0]  x_ff;
   logic                           tail_ff;
   logic signed [PROD_BITS-1:0]    prod_ff;
   logic signed [PROD_BITS-1:0]    mix_ff;
   logic signed [SUM_BITS-1:0]     sum_ff;
   logic                           clip_ff;
   logic [DIV_BITS-1:0]            div_ff;
   logic [1:0]                     rem_ff;
   logic                           dneg_ff;
   logic [DCNT_BITS-1:0]           dcnt_ff;
   logic signed [MA_BITS-1:0]      avg_ff;
   logic                           rsp_valid_ff;
   rsp_word_type                   rsp_word_ff;

   // config
   logic [DELAY_BITS-1:0]          delay_ff [NUM_COMBS];
   logic [GAIN_BITS-1:0]           decay_ff;
   logic [WET_BITS-1:0]            wet_ff;

   // control strobes from the sequencer
   logic                           accept;
   logic                           mul_en;
   logic                           clearing;
   logic                           fb_add;
   logic                           rsp_free;
   logic                           rsp_load;
   logic [NUM_COMBS-1:0]           line_we;
   logic signed [LINE_BITS-1:0]    line_wdata;

   // datapath nets
   logic signed [MA_BITS-1:0]      mul_a;
   logic signed [MB_BITS-1:0]      mul_b;
   logic signed [PROD_BITS-1:0]    prod_in;
   logic signed [PROD_BITS-1:0]    fb_rnd;
   logic signed [RES_BITS-1:0]     fb;
   logic signed [LS_BITS-1:0]      line_sum;
   logic signed [LINE_BITS-1:0]    line_val;
   logic                           line_hit;
   logic [SUM_BITS-1:0]            sum_mag;
   logic [5:0]                     dig_t;
   logic [11:0]                    dig_prod;
   logic [3:0]                     dig_q;
   logic [5:0]                     dig_rem;
   logic signed [MA_BITS-1:0]      avg_in;
   logic signed [PROD_BITS-1:0]    mix_tot;
   logic signed [PROD_BITS-1:0]    mix_rnd;
   logic signed [RES_BITS-1:0]     mix_r;
   logic signed [SAMPLE_BITS-1:0]  out_val;
   logic                           out_hit;
   logic [GAIN_BITS-1:0]           decay_raw;
   logic [WET_BITS-1:0]            wet_raw;

   // read tap: position minus delay, delay forced into 1..LINE_DEPTH-1
   function automatic logic [AW-1:0] tap_addr(input logic [DELAY_BITS-1:0] delay,
                                              input logic [AW-1:0] pos);
      logic [CW-1:0] d;
      logic [CW-1:0] p;
      d = CW'(delay);
      p = CW'(pos);
      if (d == '0) d = CW'(1);
      if (d >= CW'(LINE_DEPTH)) d = CW'(LINE_DEPTH - 1);
      if (p >= d) tap_addr = AW'(p - d);
      else        tap_addr = AW'(p + CW'(LINE_DEPTH) - d);
   endfunction

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (wp_ff == LAST_ADDR) state_in = ST_IDLE;
         ST_IDLE:     if (req_valid) state_in = ST_READ;
         ST_READ:     state_in = ST_FB_MUL;
         ST_FB_MUL:   state_in = ST_FB_ADD;
         ST_FB_ADD:   state_in = (comb_ff == 2'(NUM_COMBS - 1)) ? ST_DIV_LOAD : ST_FB_MUL;
         ST_DIV_LOAD: state_in = ST_DIV_STEP;
         ST_DIV_STEP: if (dcnt_ff == DCNT_BITS'(DIV_DIGITS - 1)) state_in = ST_MIX_DRY;
         ST_MIX_DRY:  state_in = ST_MIX_WET;
         ST_MIX_WET:  state_in = ST_OUT;
         ST_OUT:      if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      clearing  = (state_ff == ST_CLEAR);
      fb_add    = (state_ff == ST_FB_ADD);
      mul_en    = (state_ff == ST_FB_MUL) || (state_ff == ST_MIX_DRY) ||
                  (state_ff == ST_MIX_WET);
      rsp_free  = !rsp_valid_ff || rsp_ready;
      rsp_load  = (state_ff == ST_OUT) && rsp_free;
      accept    = req_valid && req_ready;
      for (int k = 0; k < NUM_COMBS; k++) begin
         line_we[k] = clearing || (fb_add && (comb_ff == 2'(k)));
      end
      // tail words leave zero behind so feedback dies with the input
      line_wdata = (clearing || tail_ff) ? '0 : line_val;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   // ---------------------------------------------------------------- shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_FB_MUL: begin
            mul_a = MA_BITS'(rdata_ff[comb_ff]);
            mul_b = $signed({2'b00, decay_ff});
         end
         ST_MIX_DRY: begin
            mul_a = MA_BITS'(x_ff);
            mul_b = $signed({1'b0, WET_FULL - wet_ff});
         end
         ST_MIX_WET: begin
            mul_a = avg_ff;
            mul_b = $signed({1'b0, wet_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // ---------------------------------------------------------------- comb arithmetic
   always_comb begin
      // feedback: floor((p + half) / 2^16), then saturate the line to 32 bits
      fb_rnd   = prod_ff + HALF_LSB;
      fb       = fb_rnd[PROD_BITS-1:RND_SHIFT];
      line_sum = LS_BITS'(x_ff) + LS_BITS'(fb);
      line_hit = 1'b0;
      if (line_sum > LINE_HI) begin
         line_val = LINE_HI[LINE_BITS-1:0];
         line_hit = 1'b1;
      end else if (line_sum < LINE_LO) begin
         line_val = LINE_LO[LINE_BITS-1:0];
         line_hit = 1'b1;
      end else begin
         line_val = line_sum[LINE_BITS-1:0];
      end

      sum_mag  = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);

      // one quotient digit
      dig_t    = {rem_ff, div_ff[DIV_BITS-1 -: 4]};
      dig_prod = 12'(dig_t) * 12'(DIV3_RECIP);
      dig_q    = dig_prod[DIV3_SHIFT +: 4];
      dig_rem  = dig_t - {1'b0, dig_q, 1'b0} - {2'b00, dig_q};

      // truncation toward zero: divide the magnitude, restore the sign
      avg_in   = dneg_ff ? -$signed({1'b0, div_ff[LINE_BITS-1:0]})
                         :  $signed({1'b0, div_ff[LINE_BITS-1:0]});

      mix_tot  = mix_ff + prod_ff;
      mix_rnd  = mix_tot + HALF_LSB;
      mix_r    = mix_rnd[PROD_BITS-1:RND_SHIFT];
      out_hit  = 1'b0;
      if (mix_r > OUT_HI) begin
         out_val = OUT_HI[SAMPLE_BITS-1:0];
         out_hit = 1'b1;
      end else if (mix_r < OUT_LO) begin
         out_val = OUT_LO[SAMPLE_BITS-1:0];
         out_hit = 1'b1;
      end else begin
         out_val = mix_r[SAMPLE_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------- delay lines
   for (genvar k = 0; k < NUM_COMBS; k++) begin : g_line
      logic signed [LINE_BITS-1:0] line_mem [LINE_DEPTH];
      always_ff @(posedge clock) begin
         if (line_we[k]) line_mem[wp_ff] <= line_wdata;
         rdata_ff[k] <= line_mem[raddr_ff[k]];
      end
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // write pointer doubles as the sweep address while clearing
         if (clearing || (state_ff == ST_DIV_LOAD)) begin
            wp_ff <= (wp_ff == LAST_ADDR) ? '0 : wp_ff + AW'(1);
         end
         if (rsp_load)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= req_word.tail_step ? '0 : req_word.audio_sample;
         tail_ff <= req_word.tail_step;
         sum_ff  <= '0;
         clip_ff <= 1'b0;
         comb_ff <= '0;
         for (int k = 0; k < NUM_COMBS; k++) begin
            raddr_ff[k] <= tap_addr(delay_ff[k], wp_ff);
         end
      end
      if (mul_en) prod_ff <= prod_in;
      if (fb_add) begin
         sum_ff  <= sum_ff + SUM_BITS'(line_val);
         clip_ff <= clip_ff | line_hit;
         comb_ff <= comb_ff + 2'd1;
      end
      if (state_ff == ST_DIV_LOAD) begin
         div_ff  <= DIV_BITS'(sum_mag);
         dneg_ff <= sum_ff[SUM_BITS-1];
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end
      if (state_ff == ST_DIV_STEP) begin
         div_ff  <= {div_ff[DIV_BITS-5:0], dig_q};
         rem_ff  <= dig_rem[1:0];
         dcnt_ff <= dcnt_ff + DCNT_BITS'(1);
      end
      if (state_ff == ST_MIX_DRY) avg_ff <= avg_in;
      if (state_ff == ST_MIX_WET) mix_ff <= prod_ff;
      if (rsp_load) begin
         rsp_word_ff.mixed_sample <= out_val;
         rsp_word_ff.clipped      <= clip_ff | out_hit;
      end
   end

   // ---------------------------------------------------------------- csr
   assign decay_raw = csr_wdata[GAIN_BITS-1:0];
   assign wet_raw   = csr_wdata[WET_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff[0] <= DELAY_FIRST_RESET;
         delay_ff[1] <= DELAY_SECOND_RESET;
         delay_ff[2] <= DELAY_THIRD_RESET;
         decay_ff    <= DECAY_RESET;
         wet_ff      <= WET_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DELAY_FIRST:  delay_ff[0] <= csr_wdata[DELAY_BITS-1:0];
            CSR_DELAY_SECOND: delay_ff[1] <= csr_wdata[DELAY_BITS-1:0];
            CSR_DELAY_THIRD:  delay_ff[2] <= csr_wdata[DELAY_BITS-1:0];
            CSR_DECAY_GAIN: begin
               if (decay_raw < DECAY_MIN)      decay_ff <= DECAY_MIN;
               else if (decay_raw > DECAY_MAX) decay_ff <= DECAY_MAX;
               else                            decay_ff <= decay_raw;
            end
            CSR_WET_LEVEL: begin
               wet_ff <= (wet_raw > WET_FULL) ? WET_FULL : wet_raw;
            end
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

/* src/cbr_checker.sv */
`default_nettype none

module cbr_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  cbr_pkg::req_word_type               req_word,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  cbr_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [cbr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cbr_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import cbr_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // one word at a time: busy straight after taking one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high the cycle after an accept");

   // reset starts the line sweep with nothing pending
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ready or valid straight after reset");

   // a result never follows its word in the next cycle
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("rsp_valid rose one cycle after accept");

endmodule

bind comb_bank_reverb_unit cbr_checker u_cbr_checker (.*);

`default_nettype wire

/* tb/sv/comb_bank_checker.sv */
// Watches the req, rsp and csr channels of the reverb unit, keeps its own copy
// of the comb lines and settings, and checks every rsp word in order.
module comb_bank_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  cbr_pkg::req_word_type              req_word,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  cbr_pkg::rsp_word_type              rsp_word,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [cbr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cbr_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                 fail_count,
   output int                                 words_checked,
   output int                                 words_owed
);
   import cbr_pkg::*;

   localparam int     LINE_DEPTH  = LINE_DEPTH_DEFAULT;
   localparam longint LINE_MAX    = 64'sd2147483647;
   localparam longint LINE_MIN    = -64'sd2147483648;
   localparam longint OUT_MAX     = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam longint OUT_MIN     = -(64'sd1 <<< (SAMPLE_BITS - 1));

   int                    comb_line [NUM_COMBS][LINE_DEPTH];
   logic [DELAY_BITS-1:0] comb_delay [NUM_COMBS];
   logic [DELAY_BITS-1:0] line_pos;
   logic [GAIN_BITS-1:0]  decay;
   logic [WET_BITS-1:0]   wet;
   rsp_word_type          expected_mix_q [$];
   int                    fails = 0;
   int                    checked = 0;

   // floor((v + 0.5 LSB) / 2^16)
   function automatic longint round_q16(longint v);
      return (v + 64'sd32768) >>> 16;
   endfunction

   // One sample through the three combs and the dry/wet mix.
   function automatic rsp_word_type step_comb_bank(req_word_type w);
      rsp_word_type          r;
      logic [DELAY_BITS-1:0] d;
      logic [DELAY_BITS-1:0] rd;
      longint                x;
      longint                v;
      longint                sum;
      longint                mix;
      logic                  hit;
      x   = 0;
      sum = 0;
      hit = 1'b0;
      if (!w.tail_step) begin
         x = longint'(w.audio_sample);
      end
      for (int k = 0; k < NUM_COMBS; k++) begin
         d  = (comb_delay[k] == '0) ? DELAY_BITS'(1) : comb_delay[k];
         rd = line_pos - d;   // 12-bit wrap matches the 4096-deep line
         v  = x + round_q16(longint'(decay) * longint'(comb_line[k][rd]));
         if (v > LINE_MAX) begin
            v   = LINE_MAX;
            hit = 1'b1;
         end else if (v < LINE_MIN) begin
            v   = LINE_MIN;
            hit = 1'b1;
         end
         comb_line[k][line_pos] = w.tail_step ? 0 : int'(v);
         sum += v;
      end
      mix = round_q16(x * (longint'(WET_FULL) - longint'(wet))
                      + (sum / 3) * longint'(wet));
      if (mix > OUT_MAX) begin
         mix = OUT_MAX;
         hit = 1'b1;
      end else if (mix < OUT_MIN) begin
         mix = OUT_MIN;
         hit = 1'b1;
      end
      line_pos       = line_pos + 1'b1;
      r.mixed_sample = mix[SAMPLE_BITS-1:0];
      r.clipped      = hit;
      return r;
   endfunction

   task automatic apply_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      case (csr_index_type'(idx))
         CSR_DELAY_FIRST:  comb_delay[0] = data[DELAY_BITS-1:0];
         CSR_DELAY_SECOND: comb_delay[1] = data[DELAY_BITS-1:0];
         CSR_DELAY_THIRD:  comb_delay[2] = data[DELAY_BITS-1:0];
         CSR_DECAY_GAIN: begin
            decay = data[GAIN_BITS-1:0];
            if (decay < DECAY_MIN) decay = DECAY_MIN;
            if (decay > DECAY_MAX) decay = DECAY_MAX;
         end
         CSR_WET_LEVEL: begin
            wet = data[WET_BITS-1:0];
            if (wet > WET_FULL) wet = WET_FULL;
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      fails++;
      $display("%0t rsp word %0d: %s got %0d, want %0d", $time, checked, what, got, want);
   endtask

   always @(posedge clock) begin : watch
      rsp_word_type want;
      if (reset) begin
         for (int k = 0; k < NUM_COMBS; k++) begin
            for (int i = 0; i < LINE_DEPTH; i++) comb_line[k][i] = 0;
         end
         comb_delay[0] = DELAY_FIRST_RESET;
         comb_delay[1] = DELAY_SECOND_RESET;
         comb_delay[2] = DELAY_THIRD_RESET;
         decay         = DECAY_RESET;
         wet           = WET_RESET;
         line_pos      = '0;
         expected_mix_q.delete();
      end else begin
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_wdata);
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_mix_q.size() == 0) begin
               report_mismatch("unexpected word, sample", rsp_word.mixed_sample, 0);
            end else begin
               want = expected_mix_q.pop_front();
               if (rsp_word.mixed_sample !== want.mixed_sample)
                  report_mismatch("mixed_sample", rsp_word.mixed_sample, want.mixed_sample);
               if (rsp_word.clipped !== want.clipped)
                  report_mismatch("clipped", rsp_word.clipped, want.clipped);
            end
         end
         if (req_valid && req_ready)
            expected_mix_q.insert(expected_mix_q.size(), step_comb_bank(req_word));
      end
      fail_count    <= fails;
      words_checked <= checked;
      words_owed    <= expected_mix_q.size();
   end

endmodule

/* tb/sv/tb_comb_bank_reverb_unit.sv */
// Stimulus and verdict for the comb bank reverb unit. Prediction and checking
// sit in comb_bank_checker, which hands back its failure and word counts.
module tb_comb_bank_reverb_unit;
   import cbr_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 24;    // extra wait once every word owed is checked
   localparam int HOLD_CYCLES   = 400;   // long rsp hold-off, fills the unit
   localparam int PHASE_ITEMS   = 230;
   localparam int NUM_PHASES    = 6;

   // indexes outside the register map: writes must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LOW  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HIGH = 3'd7;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_word_type              req_word  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_word_type              rsp_word;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int fail_count;
   int words_checked;
   int words_owed;

   int items_sent    = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int holds_asked   = 0;
   int holds_served  = 0;
   int cycle_count   = 0;

   comb_bank_reverb_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   comb_bank_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .words_checked (words_checked),
      .words_owed    (words_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog. Worst case is roughly the line clear, then ~1400 words, plus
   // receiver stalls and sender gaps; the limit leaves plenty of headroom over that.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("comb_bank_reverb_unit: mismatch");
      $finish;
   end

   // Receiver: random back-pressure, plus one long hold-off on request from
   // the stimulus so the unit backs up and drops req_ready.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (holds_asked > holds_served) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_served++;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Offer one req word. Called at a rising edge; valid stays high after the
   // word is taken, so back-to-back words never lower and raise it in one step.
   task automatic send_sample(logic signed [SAMPLE_BITS-1:0] dry, logic tail);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word  <= '{audio_sample: dry, tail_step: tail};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // csr_valid is left high; the caller drops it after the last write
   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_bank_setting(logic [CSR_DATA_BITS-1:0] d0, logic [CSR_DATA_BITS-1:0] d1,
                                     logic [CSR_DATA_BITS-1:0] d2,
                                     logic [CSR_DATA_BITS-1:0] gain,
                                     logic [CSR_DATA_BITS-1:0] mix);
      csr_write(CSR_DELAY_FIRST, d0);
      csr_write(CSR_DELAY_SECOND, d1);
      csr_write(CSR_DELAY_THIRD, d2);
      csr_write(CSR_DECAY_GAIN, gain);
      csr_write(CSR_WET_LEVEL, mix);
      csr_valid <= 1'b0;
   endtask

   // Drain: stop offering, wait for every word owed, then let the pipe empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (words_checked != items_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly full-scale noise, with rails and quiet samples mixed in.
   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(9))
         0:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         1:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         2, 3:    return SAMPLE_BITS'(int'($urandom_range(0, 4095)) - 2048);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      int phase_start;
      int burst;
      int tail_len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      send_idle_pct = 24;
      rsp_idle_pct  = 87;
      // zero delay (acts as one), delay of one, longest delay; gain and wet
      // written above their limits so both clamp to the top
      csr_write(CSR_DELAY_FIRST, 17'd0);
      csr_write(CSR_DELAY_SECOND, 17'd1);
      csr_write(CSR_DELAY_THIRD, 17'd4095);
      csr_write(CSR_DECAY_GAIN, '1);
      csr_write(CSR_WET_LEVEL, '1);
      // spare indexes: must leave everything as it is
      csr_write(CSR_SPARE_LOW, '1);
      csr_write(CSR_SPARE_HIGH, 17'h0AAAA);
      csr_valid <= 1'b0;

      // positive rail: short lines build up, fully wet output clips
      repeat (3) send_sample(24'sh7FFFFF, 1'b0);
      // negative rail, swinging the lines the other way
      repeat (3) send_sample(24'sh800000, 1'b0);
      send_sample(24'sh000000, 1'b0);
      send_sample(-24'sd1, 1'b0);
      send_sample(24'sd1, 1'b0);
      send_sample(24'sh555555, 1'b0);
      send_sample(24'shAAAAAA, 1'b0);
      // tail steps: the dry value must be ignored, lines ring down then clear
      send_sample(24'sh7FFFFF, 1'b1);
      send_sample(24'sh800000, 1'b1);
      send_sample(24'sh123456, 1'b1);
      send_sample(24'sh000000, 1'b1);
      send_sample(-24'sd1, 1'b1);
      // back to input after a tail
      send_sample(24'sh400000, 1'b0);
      send_sample(24'shC00000, 1'b0);

      // ---- random part, several settings ----
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         case (p)
            // short lines, strongest feedback, fully wet
            0: write_bank_setting(CSR_DATA_BITS'($urandom_range(1, 16)),
                                  CSR_DATA_BITS'($urandom_range(1, 16)),
                                  CSR_DATA_BITS'($urandom_range(1, 16)),
                                  17'd64225, 17'd65536);
            // longest lines, gain below range clamps to the floor, fully dry
            1: write_bank_setting(17'd4095, 17'd4095, 17'd4095, 17'd0, 17'd0);
            // raw random data, upper bits ignored or clamped
            2: write_bank_setting(CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom),
                                  CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom),
                                  CSR_DATA_BITS'($urandom));
            // adjacent small delays, floor gain, half mix
            3: write_bank_setting(17'd1, 17'd2, 17'd3, 17'd3277, 17'd32768);
            4: write_bank_setting(CSR_DATA_BITS'($urandom_range(1, 300)),
                                  CSR_DATA_BITS'($urandom_range(1, 300)),
                                  CSR_DATA_BITS'($urandom_range(1, 300)),
                                  CSR_DATA_BITS'($urandom_range(3277, 64225)),
                                  CSR_DATA_BITS'($urandom_range(0, 65536)));
            default: write_bank_setting(CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom),
                                        CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom),
                                        CSR_DATA_BITS'($urandom));
         endcase

         // idling: sender light / receiver heavy, then swapped, then none
         send_idle_pct = (p < 2) ? 24 : (p < 4) ? 87 : 0;
         rsp_idle_pct  = (p < 2) ? 87 : (p < 4) ? 24 : 0;

         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if (p == 4 && holds_asked == 0 && items_sent - phase_start > 60) holds_asked++;
            if ($urandom_range(99) < 80) begin
               // a passage of audio followed by its tail
               burst    = $urandom_range(1, 40);
               tail_len = $urandom_range(0, 24);
               repeat (burst) send_sample(random_sample(), 1'b0);
               repeat (tail_len) send_sample(random_sample(), 1'b1);
            end else begin
               // stray tail flags dotted through the input
               repeat ($urandom_range(1, 8))
                  send_sample(random_sample(), 1'($urandom_range(0, 1)));
            end
         end
      end

      settle();
      if (fail_count == 0 && words_owed == 0) begin
         $display("comb_bank_reverb_unit: match");
      end else begin
         $display("comb_bank_reverb_unit: mismatch");
      end
      $finish;
   end

endmodule

/* sim.f */
src/cbr_pkg.sv
src/comb_bank_reverb_unit.sv
src/cbr_checker.sv
tb/sv/comb_bank_checker.sv
tb/sv/tb_comb_bank_reverb_unit.sv
